// File: design/dtfe_pkg.sv
// Shared types, constants and helper functions for the date and time field editor.
// Used by dtfe_step, datetime_field_editor and the testbench; depends on nothing else.
package dtfe_pkg;

    typedef enum logic [2:0] {
        REQ_LOAD        = 3'd0,
        REQ_BACK        = 3'd1,
        REQ_CURSOR_UP   = 3'd2,
        REQ_CURSOR_DOWN = 3'd3,
        REQ_DEC         = 3'd4,
        REQ_INC         = 3'd5,
        REQ_SELECT      = 3'd6,
        REQ_OTHER       = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        PAGE_NONE   = 2'd0,
        PAGE_REDRAW = 2'd1,
        PAGE_LEAVE  = 2'd2
    } t_page_action;

    typedef enum logic [2:0] {
        FIELD_HOUR   = 3'd0,
        FIELD_MINUTE = 3'd1,
        FIELD_SECOND = 3'd2,
        FIELD_DAY    = 3'd3,
        FIELD_MONTH  = 3'd4,
        FIELD_YEAR   = 3'd5
    } t_field;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year_off;
        t_field     cursor;
    } t_state;

    typedef struct packed {
        t_req       req;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year_off;
        logic       time_ok;
        logic       date_ok;
    } t_item;

    localparam logic [4:0]  HoursMax   = 5'd23;
    localparam logic [5:0]  MinSecMax  = 6'd59;
    localparam logic [4:0]  DayFirst   = 5'd1;
    localparam logic [3:0]  MonthFirst = 4'd1;
    localparam logic [3:0]  MonthLast  = 4'd12;
    localparam logic [6:0]  YearOffMax = 7'd99;
    localparam logic [11:0] YearBase   = 12'd2000;

    localparam t_state StateReset = '{
        hours:    5'd0,
        minutes:  6'd0,
        seconds:  6'd0,
        day:      DayFirst,
        month:    MonthFirst,
        year_off: 7'd0,
        cursor:   FIELD_HOUR
    };

    // Length of a month; February is long whenever the offset is divisible by four.
    function automatic logic [4:0] month_days(input logic [3:0] month,
                                              input logic [6:0] year_off);
        logic [4:0] days;
        begin
            unique case (month)
                4'd2:                       days = (year_off[1:0] == 2'd0) ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:    days = 5'd30;
                default:                    days = 5'd31;
            endcase
            return days;
        end
    endfunction

    function automatic logic [4:0] clamp_day(input logic [4:0] day, input logic [4:0] dim);
        logic [4:0] res;
        begin
            if (day < DayFirst) begin
                res = DayFirst;
            end else if (day > dim) begin
                res = dim;
            end else begin
                res = day;
            end
            return res;
        end
    endfunction

endpackage

// File: design/datetime_field_editor.sv
// Date and time field editor: one request word in, one result word out per request.
// A word waits in the input register until the result registers are free to take its result.
// Throughput: one word per cycle unless stalled; a stall lets the input register take one word.
// The state update sits in one short logic pass between input and result registers.
// Reset (synchronous, active low) empties both registers and sets 00:00:00 01-01-2000,
// cursor on the hour field. Depends on dtfe_pkg and dtfe_step.
module datetime_field_editor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic [4:0]  i_clock_hours,
    input  logic [5:0]  i_clock_minutes,
    input  logic [5:0]  i_clock_seconds,
    input  logic [4:0]  i_clock_day,
    input  logic [3:0]  i_clock_month,
    input  logic [6:0]  i_clock_year_offset,
    input  logic        i_time_read_ok,
    input  logic        i_date_read_ok,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_page_action,
    output logic        o_commit_request,
    output logic [4:0]  o_edit_hours,
    output logic [5:0]  o_edit_minutes,
    output logic [5:0]  o_edit_seconds,
    output logic [4:0]  o_edit_day,
    output logic [3:0]  o_edit_month,
    output logic [11:0] o_edit_year,
    output logic [2:0]  o_cursor_field
);
    import dtfe_pkg::*;

    t_item        n_item;
    t_item        r_item;
    logic         r_in_valid;
    t_state       r_state;
    t_state       n_state;
    t_page_action n_action;
    t_page_action r_action;
    logic         n_commit;
    logic         r_commit;
    logic         r_out_valid;
    logic         advance;

    assign n_item = '{
        req:      t_req'(i_req_type),
        hours:    i_clock_hours,
        minutes:  i_clock_minutes,
        seconds:  i_clock_seconds,
        day:      i_clock_day,
        month:    i_clock_month,
        year_off: i_clock_year_offset,
        time_ok:  i_time_read_ok,
        date_ok:  i_date_read_ok
    };

    // The state moves only when a result is loaded, so it always matches the result held.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    dtfe_step u_step (
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_action (n_action),
        .o_commit (n_commit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= StateReset;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= n_item;
        end
        if (advance) begin
            r_action <= n_action;
            r_commit <= n_commit;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_page_action    = r_action;
    assign o_commit_request = r_commit;
    assign o_edit_hours     = r_state.hours;
    assign o_edit_minutes   = r_state.minutes;
    assign o_edit_seconds   = r_state.seconds;
    assign o_edit_day       = r_state.day;
    assign o_edit_month     = r_state.month;
    assign o_edit_year      = YearBase + {5'd0, r_state.year_off};
    assign o_cursor_field   = r_state.cursor;

    a_day_in_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.day >= DayFirst) &&
        (r_state.day <= month_days(r_state.month, r_state.year_off)))
        else $error("edited day outside the month length");

    a_fields_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.month >= MonthFirst) && (r_state.month <= MonthLast) &&
        (r_state.year_off <= YearOffMax) && (r_state.hours <= HoursMax) &&
        (r_state.minutes <= MinSecMax) && (r_state.seconds <= MinSecMax))
        else $error("edited field out of range");

    a_state_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_state))
        else $error("state changed while a result was stalled");

    a_cursor_home_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_item.req == REQ_LOAD) |=> (r_state.cursor == FIELD_HOUR))
        else $error("cursor not on hour field after load");

endmodule

// File: design/dtfe_step.sv
// Next-state logic of the editor: applies one request word to the edited fields.
// Purely combinational; depends on dtfe_pkg.
module dtfe_step (
    input  dtfe_pkg::t_state       i_state,
    input  dtfe_pkg::t_item        i_item,
    output dtfe_pkg::t_state       o_state,
    output dtfe_pkg::t_page_action o_action,
    output logic                   o_commit
);
    import dtfe_pkg::*;

    logic [3:0] ld_month;
    logic [6:0] ld_year;
    logic [4:0] dim_now;
    logic [3:0] step_month;
    logic [6:0] step_year;
    logic       up;

    // Saturated date fields from the clock read.
    always_comb begin
        if (i_item.month < MonthFirst) begin
            ld_month = MonthFirst;
        end else if (i_item.month > MonthLast) begin
            ld_month = MonthLast;
        end else begin
            ld_month = i_item.month;
        end
        ld_year = (i_item.year_off > YearOffMax) ? YearOffMax : i_item.year_off;
    end

    assign up      = (i_item.req == REQ_INC);
    assign dim_now = month_days(i_state.month, i_state.year_off);

    always_comb begin
        if (up) begin
            step_month = (i_state.month >= MonthLast) ? MonthFirst : i_state.month + 4'd1;
            step_year  = (i_state.year_off >= YearOffMax) ? 7'd0 : i_state.year_off + 7'd1;
        end else begin
            step_month = (i_state.month <= MonthFirst) ? MonthLast : i_state.month - 4'd1;
            step_year  = (i_state.year_off == 7'd0) ? YearOffMax : i_state.year_off - 7'd1;
        end
    end

    always_comb begin
        o_state  = i_state;
        o_action = PAGE_REDRAW;
        o_commit = 1'b0;
        unique case (i_item.req)
            REQ_LOAD: begin
                if (i_item.time_ok) begin
                    o_state.hours   = (i_item.hours > HoursMax) ? HoursMax : i_item.hours;
                    o_state.minutes = (i_item.minutes > MinSecMax) ? MinSecMax : i_item.minutes;
                    o_state.seconds = (i_item.seconds > MinSecMax) ? MinSecMax : i_item.seconds;
                end
                if (i_item.date_ok) begin
                    o_state.day      = clamp_day(i_item.day, month_days(ld_month, ld_year));
                    o_state.month    = ld_month;
                    o_state.year_off = ld_year;
                end else begin
                    o_state.day      = DayFirst;
                    o_state.month    = MonthFirst;
                    o_state.year_off = 7'd0;
                end
                o_state.cursor = FIELD_HOUR;
            end
            REQ_BACK: begin
                o_action = PAGE_LEAVE;
            end
            REQ_CURSOR_UP: begin
                o_state.cursor = (i_state.cursor == FIELD_HOUR) ? FIELD_YEAR
                               : t_field'(3'(i_state.cursor - 3'd1));
            end
            REQ_CURSOR_DOWN: begin
                o_state.cursor = (i_state.cursor == FIELD_YEAR) ? FIELD_HOUR
                               : t_field'(3'(i_state.cursor + 3'd1));
            end
            REQ_DEC, REQ_INC: begin
                unique case (i_state.cursor)
                    FIELD_HOUR: begin
                        if (up) begin
                            o_state.hours = (i_state.hours >= HoursMax) ? 5'd0
                                          : i_state.hours + 5'd1;
                        end else begin
                            o_state.hours = (i_state.hours == 5'd0) ? HoursMax
                                          : i_state.hours - 5'd1;
                        end
                    end
                    FIELD_MINUTE: begin
                        if (up) begin
                            o_state.minutes = (i_state.minutes >= MinSecMax) ? 6'd0
                                            : i_state.minutes + 6'd1;
                        end else begin
                            o_state.minutes = (i_state.minutes == 6'd0) ? MinSecMax
                                            : i_state.minutes - 6'd1;
                        end
                    end
                    FIELD_SECOND: begin
                        if (up) begin
                            o_state.seconds = (i_state.seconds >= MinSecMax) ? 6'd0
                                            : i_state.seconds + 6'd1;
                        end else begin
                            o_state.seconds = (i_state.seconds == 6'd0) ? MinSecMax
                                            : i_state.seconds - 6'd1;
                        end
                    end
                    FIELD_DAY: begin
                        if (up) begin
                            o_state.day = (i_state.day >= dim_now) ? DayFirst
                                        : i_state.day + 5'd1;
                        end else begin
                            o_state.day = (i_state.day <= DayFirst) ? dim_now
                                        : i_state.day - 5'd1;
                        end
                    end
                    FIELD_MONTH: begin
                        o_state.month = step_month;
                        o_state.day   = clamp_day(i_state.day,
                                                  month_days(step_month, i_state.year_off));
                    end
                    FIELD_YEAR: begin
                        o_state.year_off = step_year;
                        o_state.day      = clamp_day(i_state.day,
                                                     month_days(i_state.month, step_year));
                    end
                    default: begin
                        o_state = i_state;
                    end
                endcase
            end
            REQ_SELECT: begin
                o_commit = 1'b1;
            end
            REQ_OTHER: begin
                o_action = PAGE_NONE;
            end
            default: begin
                o_action = PAGE_NONE;
            end
        endcase
    end

endmodule

// File: verif/datetime_field_editor_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the date and time field editor: a directed table, then random
// words under varied sender and receiver idling. Depends on dtfe_pkg and datetime_field_editor.
module datetime_field_editor_test;
    import dtfe_pkg::*;

    localparam int CycleLimit = 400000;
    localparam int RandomPerPhase = 400;

    typedef struct packed {
        t_page_action page;
        logic         commit;
        logic [4:0]   hours;
        logic [5:0]   minutes;
        logic [5:0]   seconds;
        logic [4:0]   day;
        logic [3:0]   month;
        logic [11:0]  year;
        t_field       cursor;
    } t_result;

    typedef struct {
        t_item   word;
        bit      typed;
        t_result res;
    } t_row;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    out_ready = 1'b0;
    t_item   word_q = '0;
    logic    row_typed = 1'b0;
    t_result row_res = '0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_page_action;
    logic        o_commit_request;
    logic [4:0]  o_edit_hours;
    logic [5:0]  o_edit_minutes;
    logic [5:0]  o_edit_seconds;
    logic [4:0]  o_edit_day;
    logic [3:0]  o_edit_month;
    logic [11:0] o_edit_year;
    logic [2:0]  o_cursor_field;

    t_state  edit_state = StateReset;
    t_result pending_edits[$];
    t_row    dir_rows[$];
    int      idle_pct = 0;
    int      stall_pct = 0;
    int      cycle_count = 0;
    bit      failed = 1'b0;

    datetime_field_editor dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (o_in_ready),
        .i_req_type          (word_q.req),
        .i_clock_hours       (word_q.hours),
        .i_clock_minutes     (word_q.minutes),
        .i_clock_seconds     (word_q.seconds),
        .i_clock_day         (word_q.day),
        .i_clock_month       (word_q.month),
        .i_clock_year_offset (word_q.year_off),
        .i_time_read_ok      (word_q.time_ok),
        .i_date_read_ok      (word_q.date_ok),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (out_ready),
        .o_page_action       (o_page_action),
        .o_commit_request    (o_commit_request),
        .o_edit_hours        (o_edit_hours),
        .o_edit_minutes      (o_edit_minutes),
        .o_edit_seconds      (o_edit_seconds),
        .o_edit_day          (o_edit_day),
        .o_edit_month        (o_edit_month),
        .o_edit_year         (o_edit_year),
        .o_cursor_field      (o_cursor_field)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [4:0] month_length(input logic [3:0] mon, input logic [6:0] yoff);
        if (mon == 4'd2) begin
            return (yoff % 4 == 0) ? 5'd29 : 5'd28;
        end
        if (mon == 4'd4 || mon == 4'd6 || mon == 4'd9 || mon == 4'd11) begin
            return 5'd30;
        end
        return 5'd31;
    endfunction

    function automatic void fit_day();
        logic [4:0] dim;
        dim = month_length(edit_state.month, edit_state.year_off);
        if (edit_state.day < DayFirst) begin
            edit_state.day = DayFirst;
        end
        if (edit_state.day > dim) begin
            edit_state.day = dim;
        end
    endfunction

    function automatic void step_selected(input bit up);
        logic [4:0] dim;
        dim = month_length(edit_state.month, edit_state.year_off);
        case (edit_state.cursor)
            FIELD_HOUR: begin
                if (up) begin
                    edit_state.hours = (edit_state.hours >= HoursMax) ? 5'd0
                                                                      : edit_state.hours + 5'd1;
                end else begin
                    edit_state.hours = (edit_state.hours == 5'd0) ? HoursMax
                                                                  : edit_state.hours - 5'd1;
                end
            end
            FIELD_MINUTE: begin
                if (up) begin
                    edit_state.minutes = (edit_state.minutes >= MinSecMax) ? 6'd0
                                                                           : edit_state.minutes + 6'd1;
                end else begin
                    edit_state.minutes = (edit_state.minutes == 6'd0) ? MinSecMax
                                                                      : edit_state.minutes - 6'd1;
                end
            end
            FIELD_SECOND: begin
                if (up) begin
                    edit_state.seconds = (edit_state.seconds >= MinSecMax) ? 6'd0
                                                                           : edit_state.seconds + 6'd1;
                end else begin
                    edit_state.seconds = (edit_state.seconds == 6'd0) ? MinSecMax
                                                                      : edit_state.seconds - 6'd1;
                end
            end
            FIELD_DAY: begin
                if (up) begin
                    edit_state.day = (edit_state.day >= dim) ? DayFirst : edit_state.day + 5'd1;
                end else begin
                    edit_state.day = (edit_state.day <= DayFirst) ? dim : edit_state.day - 5'd1;
                end
            end
            FIELD_MONTH: begin
                if (up) begin
                    edit_state.month = (edit_state.month >= MonthLast) ? MonthFirst
                                                                       : edit_state.month + 4'd1;
                end else begin
                    edit_state.month = (edit_state.month <= MonthFirst) ? MonthLast
                                                                        : edit_state.month - 4'd1;
                end
                fit_day();
            end
            FIELD_YEAR: begin
                if (up) begin
                    edit_state.year_off = (edit_state.year_off >= YearOffMax) ? 7'd0
                                                                              : edit_state.year_off + 7'd1;
                end else begin
                    edit_state.year_off = (edit_state.year_off == 7'd0) ? YearOffMax
                                                                        : edit_state.year_off - 7'd1;
                end
                fit_day();
            end
            default: begin
            end
        endcase
    endfunction

    // Applies one request word to the edited state and gives the result word it should produce.
    function automatic t_result advance_editor(input t_item w);
        t_result r;
        r.page = PAGE_REDRAW;
        r.commit = 1'b0;
        case (w.req)
            REQ_LOAD: begin
                if (w.time_ok) begin
                    edit_state.hours = (w.hours > HoursMax) ? HoursMax : w.hours;
                    edit_state.minutes = (w.minutes > MinSecMax) ? MinSecMax : w.minutes;
                    edit_state.seconds = (w.seconds > MinSecMax) ? MinSecMax : w.seconds;
                end
                if (w.date_ok) begin
                    edit_state.day = w.day;
                    edit_state.month = (w.month < MonthFirst) ? MonthFirst
                                     : (w.month > MonthLast) ? MonthLast : w.month;
                    edit_state.year_off = (w.year_off > YearOffMax) ? YearOffMax : w.year_off;
                end else begin
                    edit_state.day = DayFirst;
                    edit_state.month = MonthFirst;
                    edit_state.year_off = 7'd0;
                end
                fit_day();
                edit_state.cursor = FIELD_HOUR;
            end
            REQ_BACK:        r.page = PAGE_LEAVE;
            REQ_CURSOR_UP:   edit_state.cursor = (edit_state.cursor == FIELD_HOUR) ? FIELD_YEAR
                                               : t_field'(edit_state.cursor - 3'd1);
            REQ_CURSOR_DOWN: edit_state.cursor = (edit_state.cursor == FIELD_YEAR) ? FIELD_HOUR
                                               : t_field'(edit_state.cursor + 3'd1);
            REQ_DEC:         step_selected(1'b0);
            REQ_INC:         step_selected(1'b1);
            REQ_SELECT:      r.commit = 1'b1;
            default:         r.page = PAGE_NONE;
        endcase
        r.hours = edit_state.hours;
        r.minutes = edit_state.minutes;
        r.seconds = edit_state.seconds;
        r.day = edit_state.day;
        r.month = edit_state.month;
        r.year = YearBase + 12'(edit_state.year_off);
        r.cursor = edit_state.cursor;
        return r;
    endfunction

    function automatic t_item mk_word(input t_req r, input logic [4:0] h, input logic [5:0] mi,
                                      input logic [5:0] s, input logic [4:0] d,
                                      input logic [3:0] mo, input logic [6:0] y,
                                      input logic tok, input logic dok);
        t_item w;
        w.req = r;
        w.hours = h;
        w.minutes = mi;
        w.seconds = s;
        w.day = d;
        w.month = mo;
        w.year_off = y;
        w.time_ok = tok;
        w.date_ok = dok;
        return w;
    endfunction

    function automatic t_result mk_res(input t_page_action p, input logic c, input logic [4:0] h,
                                       input logic [5:0] mi, input logic [5:0] s,
                                       input logic [4:0] d, input logic [3:0] mo,
                                       input logic [11:0] yr, input t_field cur);
        t_result r;
        r.page = p;
        r.commit = c;
        r.hours = h;
        r.minutes = mi;
        r.seconds = s;
        r.day = d;
        r.month = mo;
        r.year = yr;
        r.cursor = cur;
        return r;
    endfunction

    // Mostly cursor moves and steps so that the edited fields walk through their wraps;
    // loads are rarer and a quarter of them carry raw random, possibly out-of-range clock values.
    function automatic t_item random_word();
        t_item w;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            w.req = REQ_LOAD;
        end else if (pick < 12) begin
            w.req = REQ_BACK;
        end else if (pick < 26) begin
            w.req = REQ_CURSOR_UP;
        end else if (pick < 40) begin
            w.req = REQ_CURSOR_DOWN;
        end else if (pick < 64) begin
            w.req = REQ_DEC;
        end else if (pick < 88) begin
            w.req = REQ_INC;
        end else if (pick < 94) begin
            w.req = REQ_SELECT;
        end else begin
            w.req = REQ_OTHER;
        end
        if (w.req == REQ_LOAD && $urandom_range(0, 3) != 0) begin
            w.hours = 5'($urandom_range(0, 23));
            w.minutes = 6'($urandom_range(0, 59));
            w.seconds = 6'($urandom_range(0, 59));
            w.day = 5'($urandom);
            w.month = 4'($urandom_range(1, 12));
            w.year_off = 7'($urandom_range(0, 99));
        end else begin
            w.hours = 5'($urandom);
            w.minutes = 6'($urandom);
            w.seconds = 6'($urandom);
            w.day = 5'($urandom);
            w.month = 4'($urandom);
            w.year_off = 7'($urandom);
        end
        w.time_ok = ($urandom_range(0, 4) != 0);
        w.date_ok = ($urandom_range(0, 4) != 0);
        return w;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failed = 1'b1;
        end
    endfunction

    task automatic send_word(input t_item w, input bit typed, input t_result res);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        word_q <= w;
        row_typed <= typed;
        row_res <= res;
        do begin
            @(posedge clk);
        end while (!o_in_ready);
    endtask

    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk) begin
        t_result predicted;
        t_result want;
        if (rst_n) begin
            if (in_valid && o_in_ready) begin
                predicted = advance_editor(word_q);
                pending_edits.push_back(row_typed ? row_res : predicted);
            end
            if (o_out_valid && out_ready) begin
                if (pending_edits.size() == 0) begin
                    $error("result word arrived with no expectation waiting");
                    failed = 1'b1;
                end else begin
                    want = pending_edits.pop_front();
                    check_field("page_action", want.page, o_page_action);
                    check_field("commit_request", want.commit, o_commit_request);
                    check_field("edit_hours", want.hours, o_edit_hours);
                    check_field("edit_minutes", want.minutes, o_edit_minutes);
                    check_field("edit_seconds", want.seconds, o_edit_seconds);
                    check_field("edit_day", want.day, o_edit_day);
                    check_field("edit_month", want.month, o_edit_month);
                    check_field("edit_year", want.year, o_edit_year);
                    check_field("cursor_field", want.cursor, o_cursor_field);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        // Rows with a typed result are the reset state, saturating loads and leap-day clamps.
        dir_rows.push_back('{mk_word(REQ_OTHER, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                             mk_res(PAGE_NONE, 0, 0, 0, 0, 1, 1, 2000, FIELD_HOUR)});
        dir_rows.push_back('{mk_word(REQ_BACK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                             mk_res(PAGE_LEAVE, 0, 0, 0, 0, 1, 1, 2000, FIELD_HOUR)});
        dir_rows.push_back('{mk_word(REQ_SELECT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                             mk_res(PAGE_REDRAW, 1, 0, 0, 0, 1, 1, 2000, FIELD_HOUR)});
        dir_rows.push_back('{mk_word(REQ_LOAD, 31, 63, 63, 31, 15, 127, 1, 1), 1'b1,
                             mk_res(PAGE_REDRAW, 0, 23, 59, 59, 31, 12, 2099, FIELD_HOUR)});
        // Each field is stepped; hour, minute, day and year wrap, and the month clamps the day.
        dir_rows.push_back('{mk_word(REQ_INC, 31, 63, 63, 31, 15, 127, 1, 1), 1'b0, '0});
        dir_rows.push_back('{mk_word(REQ_CURSOR_DOWN, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_word(REQ_INC, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_word(REQ_CURSOR_DOWN, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_word(REQ_DEC, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_word(REQ_CURSOR_DOWN, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_word(REQ_INC, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_word(REQ_DEC, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_word(REQ_CURSOR_DOWN, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_word(REQ_DEC, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_word(REQ_CURSOR_DOWN, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_word(REQ_INC, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_word(REQ_CURSOR_DOWN, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_word(REQ_CURSOR_UP, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        // A failed read keeps the time and falls back to the first day of 2000.
        dir_rows.push_back('{mk_word(REQ_LOAD, 31, 63, 63, 31, 15, 127, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_word(REQ_LOAD, 0, 0, 0, 0, 0, 0, 1, 1), 1'b1,
                             mk_res(PAGE_REDRAW, 0, 0, 0, 0, 1, 1, 2000, FIELD_HOUR)});
        dir_rows.push_back('{mk_word(REQ_LOAD, 12, 30, 45, 31, 2, 0, 1, 1), 1'b1,
                             mk_res(PAGE_REDRAW, 0, 12, 30, 45, 29, 2, 2000, FIELD_HOUR)});
        dir_rows.push_back('{mk_word(REQ_CURSOR_UP, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_word(REQ_INC, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_word(REQ_CURSOR_UP, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_word(REQ_DEC, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        foreach (dir_rows[k]) begin
            send_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].res);
        end
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            repeat (RandomPerPhase) begin
                send_word(random_word(), 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        while (pending_edits.size() != 0) begin
            @(posedge clk);
        end
        // Give a stray extra word time to show up before the verdict.
        repeat (20) @(posedge clk);
        if (!failed) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
